// ===== rtl/core/mersenne_twister_generator_defines.svh =====
// ----------------------------------------------------------------------------
// mersenne twister generator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// same-cycle implication
`define MTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtg assertion failed");

// next-cycle implication
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtg assertion failed");

`endif

// ===== rtl/core/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// constants, command and status types and tempering for the generator
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int MT_DEPTH = 624;
    localparam int MT_IDX_W = 10;

    typedef logic [MT_IDX_W-1:0] t_idx;
    typedef logic [31:0]         t_word;

    localparam t_idx MT_SIZE     = 10'd624;
    localparam t_idx MT_LAST     = 10'd623;
    localparam t_idx MT_SHIFT    = 10'd397;
    localparam t_idx MT_NXT_WRAP = 10'd622;
    localparam t_idx MT_FAR_WRAP = 10'd226;
    localparam t_idx MT_FAR_NEXT = 10'd398;

    localparam t_word MT_MATRIX       = 32'h9908_b0df;
    localparam t_word MT_HIGH_BIT     = 32'h8000_0000;
    localparam t_word MT_LOW_BITS     = 32'h7fff_ffff;
    localparam t_word MT_TEMPER_B     = 32'h9d2c_5680;
    localparam t_word MT_TEMPER_C     = 32'hefc6_0000;
    localparam t_word MT_SEED_MULT    = 32'd69069;
    localparam t_word MT_DEFAULT_SEED = 32'd4375;

    typedef enum logic {
        OP_SEED = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        RD_POS   = 2'd0,
        RD_FIRST = 2'd1,
        RD_LOAD  = 2'd2,
        RD_TWIST = 2'd3
    } t_rd_mode;

    typedef struct packed {
        logic     seed_start;
        logic     seed_dflt;
        logic     seed_step;
        logic     regen_init;
        logic     regen_load;
        logic     regen_step;
        logic     out_load;
        t_rd_mode rd_mode;
    } t_cmd;

    typedef struct packed {
        logic pos_full;
        logic idx_last;
        logic out_free;
    } t_sts;

    function automatic t_word temper(input t_word y_in);
        t_word y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/core/mersenne_twister_generator.sv =====
// draw: result tempered into the output register from the draw state, which waits while
//   the output is stalled; no new request is taken until it is loaded; every 624th draw
//   first runs the table twist (one table entry per cycle, two-read, one-write memory)
// seed: one table entry per cycle through the seed multiplier
// first draw without a seed adds a default seeding pass
// reset: synchronous, active low; clears control, table contents left as is
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// mt19937 generator with multiplicative seeding, top level
// ----------------------------------------------------------------------------
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value
);

    t_cmd cmd;
    t_sts sts;

    mtg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    mtg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_value (i_seed_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_value      (o_value)
    );

endmodule

// ===== rtl/core/mtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtg_ctrl
// sequencer for seeding, table regeneration and draws
// ----------------------------------------------------------------------------
module mtg_ctrl
    import mtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    output logic o_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEED  = 7'b0000010,
        S_PRIME = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_TWIST = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DRAW  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_seeded, n_seeded;
    logic   r_draw, n_draw;

    always_comb begin
        n_state  = r_state;
        n_seeded = r_seeded;
        n_draw   = r_draw;
        o_cmd    = '0;
        o_cmd.rd_mode = RD_POS;
        o_stall  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_op == OP_SEED) begin
                        o_cmd.seed_start = 1'b1;
                        n_draw  = 1'b0;
                        n_state = S_SEED;
                    end else if (!r_seeded) begin
                        o_cmd.seed_start = 1'b1;
                        o_cmd.seed_dflt  = 1'b1;
                        n_draw  = 1'b1;
                        n_state = S_SEED;
                    end else if (i_sts.pos_full) begin
                        n_state = S_PRIME;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_seeded = 1'b1;
                    n_state  = r_draw ? S_PRIME : S_IDLE;
                end
            end
            S_PRIME: begin
                o_cmd.regen_init = 1'b1;
                o_cmd.rd_mode    = RD_FIRST;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.regen_load = 1'b1;
                o_cmd.rd_mode    = RD_LOAD;
                n_state = S_TWIST;
            end
            S_TWIST: begin
                o_cmd.regen_step = 1'b1;
                o_cmd.rd_mode    = RD_TWIST;
                if (i_sts.idx_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DRAW;
            end
            S_DRAW: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_draw   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_draw   <= n_draw;
        end
    end

endmodule

// ===== rtl/core/mtg_datapath.sv =====
// ----------------------------------------------------------------------------
// mtg_datapath
// state table, seed multiplier, twist and tempering, output register
// ----------------------------------------------------------------------------
module mtg_datapath
    import mtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed_value,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [31:0] o_value
);

    t_word r_table [MT_DEPTH];

    t_idx  r_position, n_position;
    t_idx  r_idx, n_idx;
    t_word r_seed_word, n_seed_word;
    t_word r_cur, n_cur;
    t_word r_rd_a, r_rd_b;
    logic  r_out_valid, n_out_valid;
    t_word r_out_value, n_out_value;

    t_idx  rd_a_addr, rd_b_addr;
    logic  wr_en;
    t_word wr_data;
    t_word twist_y;
    t_word twist_word;
    t_word seed_in;
    logic  out_free;

    // read address selection
    always_comb begin
        case (i_cmd.rd_mode)
            RD_POS: begin
                rd_a_addr = r_position;
                rd_b_addr = r_position;
            end
            RD_FIRST: begin
                rd_a_addr = '0;
                rd_b_addr = '0;
            end
            RD_LOAD: begin
                rd_a_addr = 10'd1;
                rd_b_addr = MT_SHIFT;
            end
            RD_TWIST: begin
                rd_a_addr = (r_idx >= MT_NXT_WRAP) ? r_idx - MT_NXT_WRAP : r_idx + 10'd2;
                rd_b_addr = (r_idx >= MT_FAR_WRAP) ? r_idx - MT_FAR_WRAP
                                                   : r_idx + MT_FAR_NEXT;
            end
            default: begin
                rd_a_addr = r_position;
                rd_b_addr = r_position;
            end
        endcase
    end

    // twist of one entry
    assign twist_y    = (r_cur & MT_HIGH_BIT) | (r_rd_a & MT_LOW_BITS);
    assign twist_word = r_rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);

    assign seed_in  = (i_cmd.seed_dflt || i_seed_value == '0) ? MT_DEFAULT_SEED
                                                              : i_seed_value;
    assign out_free = !r_out_valid || !i_stall;

    assign wr_en   = i_cmd.seed_step || i_cmd.regen_step;
    assign wr_data = i_cmd.seed_step ? r_seed_word : twist_word;

    always_comb begin
        n_position  = r_position;
        n_idx       = r_idx;
        n_seed_word = r_seed_word;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        if (i_cmd.seed_start) begin
            n_seed_word = seed_in;
            n_idx       = '0;
        end
        if (i_cmd.seed_step) begin
            n_seed_word = 32'(r_seed_word * MT_SEED_MULT);
            n_idx       = r_idx + 10'd1;
            if (r_idx == MT_LAST) begin
                n_position = MT_SIZE;
            end
        end
        if (i_cmd.regen_init) begin
            n_idx = '0;
        end
        if (i_cmd.regen_load) begin
            n_cur = r_rd_a;
        end
        if (i_cmd.regen_step) begin
            n_cur = r_rd_a;
            n_idx = r_idx + 10'd1;
            if (r_idx == MT_LAST) begin
                n_position = '0;
            end
        end
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_value = temper(r_rd_a);
            n_position  = r_position + 10'd1;
        end
    end

    // state table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_idx] <= wr_data;
        end
        r_rd_a <= r_table[rd_a_addr];
        r_rd_b <= r_table[rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= MT_SIZE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_position  <= n_position;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed_word <= n_seed_word;
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
    end

    assign o_sts.pos_full = (r_position >= MT_SIZE);
    assign o_sts.idx_last = (r_idx == MT_LAST);
    assign o_sts.out_free = out_free;
    assign o_valid        = r_out_valid;
    assign o_value        = r_out_value;

endmodule

// ===== rtl/core/mtg_checker.sv =====
// ----------------------------------------------------------------------------
// mtg_checker
// port-level checks on the generator, bound to the top level
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_defines.svh"

module mtg_checker
    import mtg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_op,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_value
);

    // result held while stalled
    `MTG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value))

    // one transaction at a time
    `MTG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // seeding keeps the input closed after acceptance
    `MTG_ASSERT_NEXT(a_seed_busy, i_clk, i_rst_n, i_valid && !o_stall && i_op == OP_SEED,
                     o_stall ##1 o_stall)

    // idle and empty straight after reset
    `MTG_ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
